FILE: rtl/alpha_plane_unfilter_defines.svh
// Assertion macros for the alpha plane unfilter block.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef ALPHA_PLANE_UNFILTER_DEFINES_SVH
`define ALPHA_PLANE_UNFILTER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define APU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define APU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define APU_ASSERT_NOW(lbl, ante, cons, msg)
`define APU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/apu_pkg.sv
package apu_pkg;

	localparam int DATA_W      = 8;
	localparam int CNT_W       = 14;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 14;
	localparam int MODE_W      = 2;
	localparam int MAX_WIDTH_DEF = 16384;

	// filter modes
	localparam logic [MODE_W-1:0] MODE_NONE       = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_VERTICAL   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_GRADIENT   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

	// position flags of one pixel, carried with it through the pipeline
	typedef struct packed {
		logic first_col;
		logic first_row;
		logic row_end;
		logic image_end;
		logic in_range;
	} apu_pix_t;

endpackage

FILE: rtl/apu_line_mem.sv
module apu_line_mem #(
	parameter int DEPTH = apu_pkg::MAX_WIDTH_DEF,
	parameter int AW    = 14
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [apu_pkg::DATA_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [apu_pkg::DATA_W-1:0] wr_data
);

	logic [apu_pkg::DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/apu_recon.sv
module apu_recon (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [apu_pkg::MODE_W-1:0]   mode,
	input  apu_pkg::apu_pix_t            pix,
	input  logic [apu_pkg::DATA_W-1:0]   residual,
	input  logic [apu_pkg::DATA_W-1:0]   above,
	output logic [apu_pkg::DATA_W-1:0]   value
);

	logic [apu_pkg::DATA_W-1:0] left_q;
	logic [apu_pkg::DATA_W-1:0] upper_left_q;
	logic [apu_pkg::DATA_W+1:0] grad;
	logic [apu_pkg::DATA_W-1:0] grad_clamp;
	logic [apu_pkg::DATA_W-1:0] pred;

	// gradient: left + above - upper left, clamped to a byte
	always_comb begin
		grad = {2'b00, left_q} + {2'b00, above} - {2'b00, upper_left_q};
		if (grad[apu_pkg::DATA_W+1]) begin
			grad_clamp = '0;
		end else if (grad[apu_pkg::DATA_W]) begin
			grad_clamp = '1;
		end else begin
			grad_clamp = grad[apu_pkg::DATA_W-1:0];
		end
	end

	// predictor select; origin always predicts zero
	always_comb begin
		pred = '0;
		if (!(pix.first_col && pix.first_row)) begin
			case (mode)
				apu_pkg::MODE_HORIZONTAL: pred = pix.first_col ? above : left_q;
				apu_pkg::MODE_VERTICAL:   pred = pix.first_row ? left_q : above;
				apu_pkg::MODE_GRADIENT: begin
					if (pix.first_row) begin
						pred = left_q;
					end else if (pix.first_col) begin
						pred = above;
					end else begin
						pred = grad_clamp;
					end
				end
				default: pred = '0;
			endcase
		end
	end

	assign value = residual + pred;

	// neighbor registers follow the pixel that leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (adv) begin
			left_q       <= value;
			upper_left_q <= above;
		end
	end

endmodule

FILE: rtl/alpha_plane_unfilter.sv
// Alpha plane unfilter: inverse WebP alpha prediction, a byte per cycle unless stalled.
// Configuration: write filter_mode (index 0), image_width (1) and image_height (2)
// through cfg_valid/cfg_index/cfg_data while the block is idle; cfg_ready is always high.
// Input: one residual byte per transfer on residual_valid/residual_stall, raster order.
// Output: one transfer per input on alpha_valid/alpha_stall carrying the reconstructed
// byte with row_end and image_end marks; image_end closes the image and the position
// counters wrap to the origin for the next one.
// Path: accepted residual -> reconstruction stage register -> output register.
// Throughput: one pixel per cycle while the output is not stalled. The line buffer is
// one synchronous RAM of MAX_WIDTH bytes, read at accept and written when the pixel
// leaves the reconstruction stage; a same-column write and read in the same cycle are
// resolved by a forwarding register. The left-pixel feedback (gradient add, subtract
// and clamp, predictor select, residual add) is closed inside the reconstruction stage.
// Stall: while alpha_stall holds a full output register, the reconstruction stage holds
// its pixel and residual_stall rises; otherwise a new residual is taken every cycle.
// Reset: counters, neighbors, modes and valid flags clear at once (width and height to 1);
// the line buffer is not cleared, each column is written before it is read.
`include "alpha_plane_unfilter_defines.svh"

module alpha_plane_unfilter #(
	parameter int MAX_WIDTH = apu_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [apu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [apu_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             residual_valid,
	output logic                             residual_stall,
	input  logic [apu_pkg::DATA_W-1:0]       residual,
	output logic                             alpha_valid,
	input  logic                             alpha_stall,
	output logic [apu_pkg::DATA_W-1:0]       alpha_value,
	output logic                             row_end,
	output logic                             image_end
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = apu_pkg::CNT_W;

	// configuration registers
	logic [apu_pkg::MODE_W-1:0] mode_q;
	logic [CW-1:0]              width_q;
	logic [CW-1:0]              height_q;

	// position counters
	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;

	// reconstruction stage
	logic                        s1_valid_q;
	apu_pkg::apu_pix_t           pix_s1;
	logic [CW-1:0]               col_s1;
	logic [apu_pkg::DATA_W-1:0]  res_s1;
	logic                        fwd_s1;
	logic [apu_pkg::DATA_W-1:0]  fwd_val_s1;

	// output register
	logic                        out_valid_q;
	logic [apu_pkg::DATA_W-1:0]  out_value_q;
	logic                        out_row_end_q;
	logic                        out_image_end_q;

	logic                        out_free;
	logic                        s1_adv;
	logic                        accept;
	logic [CW:0]                 col_next;
	logic [CW:0]                 row_next;
	apu_pkg::apu_pix_t           pix_in;
	logic [apu_pkg::DATA_W-1:0]  rd_data;
	logic [apu_pkg::DATA_W-1:0]  above;
	logic [apu_pkg::DATA_W-1:0]  value;

	// handshake
	assign out_free       = !out_valid_q || !alpha_stall;
	assign s1_adv         = s1_valid_q && out_free;
	assign residual_stall = s1_valid_q && !out_free;
	assign accept         = residual_valid && !residual_stall;
	assign cfg_ready      = 1'b1;

	// configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= apu_pkg::MODE_NONE;
			width_q  <= CW'(1);
			height_q <= CW'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				apu_pkg::CFG_FILTER_MODE:  mode_q   <= cfg_data[apu_pkg::MODE_W-1:0];
				apu_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[CW-1:0];
				apu_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// position of the incoming pixel; a zero size behaves as one
	always_comb begin
		col_next         = {1'b0, col_q} + (CW+1)'(1);
		row_next         = {1'b0, row_q} + (CW+1)'(1);
		pix_in.first_col = (col_q == '0);
		pix_in.first_row = (row_q == '0);
		pix_in.row_end   = (col_next >= {1'b0, width_q});
		pix_in.image_end = pix_in.row_end && (row_next >= {1'b0, height_q});
		pix_in.in_range  = ({1'b0, col_q} < (CW+1)'(MAX_WIDTH));
	end

	// counters advance at each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pix_in.row_end) begin
				col_q <= '0;
				row_q <= pix_in.image_end ? '0 : row_next[CW-1:0];
			end else begin
				col_q <= col_next[CW-1:0];
			end
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage payload; forward the value being written when the columns match
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pix_in;
			col_s1     <= col_q;
			res_s1     <= residual;
			fwd_s1     <= s1_adv && pix_s1.in_range && (col_s1 == col_q);
			fwd_val_s1 <= value;
		end
	end

	apu_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (s1_adv && pix_s1.in_range),
		.wr_addr (col_s1[AW-1:0]),
		.wr_data (value)
	);

	// pixel above: zero past the buffer, forwarded on a back-to-back hit
	always_comb begin
		if (!pix_s1.in_range) begin
			above = '0;
		end else if (fwd_s1) begin
			above = fwd_val_s1;
		end else begin
			above = rd_data;
		end
	end

	apu_recon u_recon (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (s1_adv),
		.mode     (mode_q),
		.pix      (pix_s1),
		.residual (res_s1),
		.above    (above),
		.value    (value)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!alpha_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_value_q     <= value;
			out_row_end_q   <= pix_s1.row_end;
			out_image_end_q <= pix_s1.image_end;
		end
	end

	assign alpha_valid = out_valid_q;
	assign alpha_value = out_value_q;
	assign row_end     = out_row_end_q;
	assign image_end   = out_image_end_q;

	// a new pixel only enters when the held one leaves
	`APU_ASSERT_NOW(a_no_overwrite, accept && s1_valid_q, s1_adv, "pixel overwritten in stage")
	// a stalled full output register blocks the stage
	`APU_ASSERT_NOW(a_out_hold, out_valid_q && alpha_stall, !s1_adv, "output overwritten under stall")
	// every pixel leaving the stage lands in the output register
	`APU_ASSERT_NEXT(a_out_fill, s1_adv, out_valid_q, "pixel lost after stage")
	// image end only on a row end
	`APU_ASSERT_NOW(a_img_row, out_valid_q && out_image_end_q, out_row_end_q, "image end without row end")
	// a pixel entering an empty stage never takes the forwarded value
	`APU_ASSERT_NEXT(a_fwd_valid, accept && !s1_valid_q, !fwd_s1, "forward flag without pixel")

endmodule

FILE: test/alpha_plane_unfilter_tb.sv
module alpha_plane_unfilter_tb;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_AFTER  = 100;
	localparam int RANDOM_ITEMS = 1300;
	localparam logic [apu_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// one reconstructed pixel as the block should return it
	typedef struct {
		logic [apu_pkg::DATA_W-1:0] alpha_value;
		logic                       row_end;
		logic                       image_end;
	} alpha_pix_t;

	// Scoreboard: keeps its own copy of the unfilter state and the queue of
	// pixels still owed by the block.
	class unfilter_board;
		bit [apu_pkg::DATA_W-1:0]   line_mem [apu_pkg::MAX_WIDTH_DEF];
		bit [apu_pkg::DATA_W-1:0]   left_px;
		bit [apu_pkg::DATA_W-1:0]   upleft_px;
		bit [apu_pkg::CNT_W-1:0]    col;
		bit [apu_pkg::CNT_W-1:0]    row;
		bit [apu_pkg::MODE_W-1:0]   mode;
		bit [apu_pkg::CNT_W-1:0]    width = 1;
		bit [apu_pkg::CNT_W-1:0]    height = 1;
		int                         widest;
		int                         checked;
		int                         images;
		int                         errors;
		alpha_pix_t                 pending_alpha [$];

		function void set_reg(logic [apu_pkg::CFG_IDX_W-1:0] idx,
			logic [apu_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				apu_pkg::CFG_FILTER_MODE:  mode = data[apu_pkg::MODE_W-1:0];
				apu_pkg::CFG_IMAGE_WIDTH:  width = data;
				apu_pkg::CFG_IMAGE_HEIGHT: height = data;
				default: ;
			endcase
		endfunction

		// reconstruct one pixel and queue it
		function void take_residual(logic [apu_pkg::DATA_W-1:0] res);
			int                         w, h, grad;
			bit                         fc, fr;
			bit [apu_pkg::DATA_W-1:0]   above, pred, val;
			alpha_pix_t                 px;
			w = (width == 0) ? 1 : int'(width);
			h = (height == 0) ? 1 : int'(height);
			fc = (col == 0);
			fr = (row == 0);
			above = line_mem[col];
			pred = '0;
			if (!(fc && fr)) begin
				case (mode)
					apu_pkg::MODE_HORIZONTAL: pred = fc ? above : left_px;
					apu_pkg::MODE_VERTICAL:   pred = fr ? left_px : above;
					apu_pkg::MODE_GRADIENT: begin
						if (fr) pred = left_px;
						else if (fc) pred = above;
						else begin
							grad = int'(left_px) + int'(above) - int'(upleft_px);
							pred = (grad < 0) ? 8'd0 : (grad > 255) ? 8'd255 : grad[7:0];
						end
					end
					default: pred = '0;
				endcase
			end
			val = res + pred;
			line_mem[col] = val;
			left_px = val;
			upleft_px = above;
			if (int'(col) + 1 > widest) widest = int'(col) + 1;
			px.alpha_value = val;
			px.row_end = (int'(col) + 1 >= w);
			px.image_end = px.row_end && (int'(row) + 1 >= h);
			if (px.row_end) begin
				col = '0;
				row = px.image_end ? '0 : row + 1'b1;
			end else begin
				col = col + 1'b1;
			end
			pending_alpha.push_back(px);
		endfunction

		// compare one output transfer with the oldest owed pixel
		function void match_alpha(logic [apu_pkg::DATA_W-1:0] v, logic re, logic ie);
			alpha_pix_t px;
			if (pending_alpha.size() == 0) begin
				$error("alpha transfer with nothing owed: alpha_value %0d", v);
				errors++;
				return;
			end
			px = pending_alpha.pop_front();
			checked++;
			if (v !== px.alpha_value) begin
				$error("alpha_value: expected %0d, got %0d", px.alpha_value, v);
				errors++;
			end
			if (re !== px.row_end) begin
				$error("row_end: expected %0d, got %0d", px.row_end, re);
				errors++;
			end
			if (ie !== px.image_end) begin
				$error("image_end: expected %0d, got %0d", px.image_end, ie);
				errors++;
			end
			if (px.image_end) images++;
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [apu_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [apu_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           residual_valid;
	logic                           residual_stall;
	logic [apu_pkg::DATA_W-1:0]     residual;
	logic                           alpha_valid;
	logic                           alpha_stall;
	logic [apu_pkg::DATA_W-1:0]     alpha_value;
	logic                           row_end;
	logic                           image_end;

	unfilter_board sb = new;
	bit  idle_on;
	int  idle_pct;
	int  residuals_sent;
	int  cycles;

	alpha_plane_unfilter u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.residual_valid (residual_valid),
		.residual_stall (residual_stall),
		.residual       (residual),
		.alpha_valid    (alpha_valid),
		.alpha_stall    (alpha_stall),
		.alpha_value    (alpha_value),
		.row_end        (row_end),
		.image_end      (image_end)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// output check on every transfer
	always @(posedge clk) begin
		if (arst_n && alpha_valid && !alpha_stall)
			sb.match_alpha(alpha_value, row_end, image_end);
	end

	// receiver: random stall bursts plus one long hold-off
	initial begin
		int  burst_left;
		int  hold_left;
		bit  held;
		burst_left = 0;
		hold_left = 0;
		held = 1'b0;
		alpha_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sb.checked >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				alpha_stall = 1'b1;
				hold_left--;
			end else if (burst_left > 0) begin
				alpha_stall = 1'b1;
				burst_left--;
			end else if (idle_on && $urandom_range(99) < idle_pct) begin
				alpha_stall = 1'b1;
				burst_left = $urandom_range(5, 0);
			end else begin
				alpha_stall = 1'b0;
			end
		end
	end

	function automatic logic [apu_pkg::DATA_W-1:0] pick_residual();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'($urandom_range(3));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// register write, called at a falling edge
	task automatic write_reg(input logic [apu_pkg::CFG_IDX_W-1:0] idx,
		input logic [apu_pkg::CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one residual transfer, with an optional idle burst ahead of it
	task automatic push_residual(input logic [apu_pkg::DATA_W-1:0] r);
		int gap;
		if (idle_on && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(6, 1);
			residual_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		residual_valid = 1'b1;
		residual = r;
		do @(posedge clk); while (residual_stall);
		sb.take_residual(r);
		residuals_sent++;
		@(negedge clk);
	endtask

	// random pixels until the position counters are back at the origin
	task automatic finish_image();
		do push_residual(pick_residual()); while (sb.col != 0 || sb.row != 0);
	endtask

	// let every owed pixel come out so the block is idle
	task automatic drain();
		residual_valid = 1'b0;
		while (sb.pending_alpha.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// stimulus
	initial begin
		logic [apu_pkg::DATA_W-1:0] corner_px [4];
		int                         rand_start, size, part, w, h, m;
		corner_px = '{8'hff, 8'h01, 8'h80, 8'h7f};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		residual_valid = 1'b0;
		residual = '0;
		idle_on = 1'b0;
		idle_pct = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset size is one pixel: each byte is a whole image
		push_residual(8'h00);
		push_residual(8'hff);
		drain();

		// every mode on a 2x2 image
		for (m = 0; m < 4; m++) begin
			write_reg(apu_pkg::CFG_FILTER_MODE, apu_pkg::CFG_DATA_W'(m));
			write_reg(apu_pkg::CFG_IMAGE_WIDTH, 14'd2);
			write_reg(apu_pkg::CFG_IMAGE_HEIGHT, 14'd2);
			foreach (corner_px[i]) push_residual(corner_px[i]);
			drain();
		end

		// zero sizes behave as one
		write_reg(apu_pkg::CFG_IMAGE_WIDTH, 14'd0);
		write_reg(apu_pkg::CFG_IMAGE_HEIGHT, 14'd0);
		push_residual(8'h5a);
		drain();

		// mode switched in the middle of an image
		write_reg(apu_pkg::CFG_FILTER_MODE, apu_pkg::CFG_DATA_W'(apu_pkg::MODE_GRADIENT));
		write_reg(apu_pkg::CFG_IMAGE_WIDTH, 14'd3);
		write_reg(apu_pkg::CFG_IMAGE_HEIGHT, 14'd2);
		push_residual(8'hff);
		push_residual(8'hff);
		drain();
		write_reg(apu_pkg::CFG_FILTER_MODE, apu_pkg::CFG_DATA_W'(apu_pkg::MODE_VERTICAL));
		finish_image();
		drain();

		// width shrunk past the current column in the middle of a row
		write_reg(apu_pkg::CFG_FILTER_MODE, apu_pkg::CFG_DATA_W'(apu_pkg::MODE_HORIZONTAL));
		write_reg(apu_pkg::CFG_IMAGE_WIDTH, 14'd4);
		write_reg(apu_pkg::CFG_IMAGE_HEIGHT, 14'd3);
		repeat (6) push_residual(pick_residual());
		drain();
		write_reg(apu_pkg::CFG_IMAGE_WIDTH, 14'd2);
		finish_image();
		drain();

		// unused index and a mode write with upper data bits set
		write_reg(CFG_SPARE, 14'h3fff);
		write_reg(apu_pkg::CFG_FILTER_MODE, 14'h3ffe);

		// wide image, two rows, so every stored column is read back
		idle_on = 1'b1;
		idle_pct = 10;
		write_reg(apu_pkg::CFG_FILTER_MODE, apu_pkg::CFG_DATA_W'(apu_pkg::MODE_GRADIENT));
		write_reg(apu_pkg::CFG_IMAGE_WIDTH, 14'd128);
		write_reg(apu_pkg::CFG_IMAGE_HEIGHT, 14'd2);
		finish_image();
		drain();

		// tallest image, cut short by lowering the height
		write_reg(apu_pkg::CFG_FILTER_MODE, apu_pkg::CFG_DATA_W'(apu_pkg::MODE_VERTICAL));
		write_reg(apu_pkg::CFG_IMAGE_WIDTH, 14'd1);
		write_reg(apu_pkg::CFG_IMAGE_HEIGHT, 14'h3fff);
		repeat (30) push_residual(pick_residual());
		drain();
		write_reg(apu_pkg::CFG_IMAGE_HEIGHT, 14'd1);
		finish_image();
		drain();

		// random images
		rand_start = residuals_sent;
		while (residuals_sent - rand_start < RANDOM_ITEMS) begin
			if (residuals_sent - rand_start > RANDOM_ITEMS - 150) begin
				idle_on = 1'b0;
			end else begin
				idle_on = 1'b1;
				case ($urandom_range(2))
					0: idle_pct = 0;
					1: idle_pct = 20;
					default: idle_pct = 50;
				endcase
			end
			// now and then stream straight into the next image with no writes
			if ($urandom_range(3) != 0) begin
				drain();
				m = $urandom_range(3);
				if ($urandom_range(3) == 0)
					write_reg(apu_pkg::CFG_FILTER_MODE,
						{12'($urandom_range(4095)), 2'(m)});
				else
					write_reg(apu_pkg::CFG_FILTER_MODE, apu_pkg::CFG_DATA_W'(m));
				case ($urandom_range(9))
					0: w = 0;
					1: w = $urandom_range(64, 13);
					2: w = $urandom_range(300, 100);
					default: w = $urandom_range(12, 1);
				endcase
				h = (w > 64) ? $urandom_range(2, 1) : $urandom_range(6, 0);
				write_reg(apu_pkg::CFG_IMAGE_WIDTH, apu_pkg::CFG_DATA_W'(w));
				write_reg(apu_pkg::CFG_IMAGE_HEIGHT, apu_pkg::CFG_DATA_W'(h));
				if ($urandom_range(7) == 0)
					write_reg(CFG_SPARE, apu_pkg::CFG_DATA_W'($urandom_range(16383)));
			end
			w = (sb.width == 0) ? 1 : int'(sb.width);
			h = (sb.height == 0) ? 1 : int'(sb.height);
			size = w * h;
			// stop part way and change one register before the rest
			if (size > 1 && $urandom_range(4) == 0) begin
				part = $urandom_range(size - 1, 1);
				repeat (part) push_residual(pick_residual());
				drain();
				case ($urandom_range(2))
					0: write_reg(apu_pkg::CFG_FILTER_MODE,
						apu_pkg::CFG_DATA_W'($urandom_range(3)));
					1: begin
						// later rows may only read columns already stored
						w = (sb.widest < 16) ? sb.widest : 16;
						if (sb.row == 0) w = 16;
						write_reg(apu_pkg::CFG_IMAGE_WIDTH,
							apu_pkg::CFG_DATA_W'($urandom_range(w, 0)));
					end
					default: write_reg(apu_pkg::CFG_IMAGE_HEIGHT,
						apu_pkg::CFG_DATA_W'($urandom_range(6, 0)));
				endcase
			end
			finish_image();
		end

		drain();
		repeat (8) @(posedge clk);
		foreach (sb.pending_alpha[i]) begin
			$error("alpha_value %0d never returned", sb.pending_alpha[i].alpha_value);
			sb.errors++;
		end
		$display("Covered %0d residuals in %0d images, all four modes, widths up to 300.",
			residuals_sent, sb.images);
		$display("%0d pixels checked with random stalls on both sides and one long output hold.",
			sb.checked);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: alpha_plane_unfilter.f
+incdir+rtl
rtl/apu_pkg.sv
rtl/apu_line_mem.sv
rtl/apu_recon.sv
rtl/alpha_plane_unfilter.sv
test/alpha_plane_unfilter_tb.sv
